FILE: design/smt_pkg.sv
// shared types and constants for the sorted multiset table
// used by smt_cell and sorted_multiset_table; no other dependencies
package smt_pkg;

  localparam int DEF_MAX_DISTINCT = 16;
  localparam int DEF_MAX_TOTAL    = 65535;

  localparam int VAL_W = 32;
  localparam int CNT_W = 16;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               cmp;
    logic               inc;
    logic               dec;
    logic               del;
    logic               ins;
    logic               descending;
    logic [VAL_W-1:0]   value;
  } ctrl_t;

  // handed from each cell to its right neighbor
  typedef struct packed {
    logic               seen_match;
    logic               seen_before;
    logic [CNT_W-1:0]   cnt;
  } chain_t;

endpackage

FILE: design/sorted_multiset_table.sv
// Sorted multiset table. A request goes through a compare and an update cycle. In the
// compare cycle every cell checks the request value against its entry for equality and
// order; in the update cycle the found flag, the current count and the insert point
// ripple down the cell chain, the cells bump, shift left for a removal or shift right
// for an insert, and the response is loaded into the output register. A new request is
// taken during the update cycle but never during the compare cycle; a stalled response
// holds the update cycle. MAX_DISTINCT, the chain length, sets the update critical path.
// top level: controller and the chain of smt_cell instances; depends on smt_pkg and smt_cell
module sorted_multiset_table #(
  parameter int MAX_DISTINCT = smt_pkg::DEF_MAX_DISTINCT,
  parameter int MAX_TOTAL    = smt_pkg::DEF_MAX_TOTAL
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                req_type,
  input  logic signed [31:0]        item_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [15:0]               occurrences,
  output logic [15:0]               total_items
);

  localparam int UW = $clog2(MAX_DISTINCT + 1);
  localparam int VW = smt_pkg::VAL_W;
  localparam int CW = smt_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic          descending;
  logic [1:0]    req;
  logic [VW-1:0] value;
  logic [UW-1:0] used;
  logic [CW-1:0] total;

  logic          accept;
  logic          out_blocked;
  logic          do_upd;

  smt_pkg::ctrl_t  ctrl;
  smt_pkg::chain_t chain [MAX_DISTINCT+1];
  logic [VW-1:0]   cell_val [MAX_DISTINCT];
  logic [CW-1:0]   cell_cnt [MAX_DISTINCT];
  logic [MAX_DISTINCT-1:0] cell_vld;
  logic [MAX_DISTINCT-1:0] cell_match;

  logic          found;
  logic [CW-1:0] cur_cnt;
  logic          full;
  logic [1:0]    status_c;
  logic [CW-1:0] occ_c;

  function automatic logic [1:0] ST_OK_SEL(input logic hit);
    return hit ? smt_pkg::ST_OK : smt_pkg::ST_NOTFOUND;
  endfunction

  assign out_blocked = out_valid && out_stall;
  assign do_upd      = (state == S_UPD) && !out_blocked;
  assign in_stall    = rst || (state == S_CMP) || ((state == S_UPD) && out_blocked);
  assign accept      = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP: state_next = S_UPD;
      S_UPD: begin
        if (accept) state_next = S_CMP;
        else if (do_upd) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      descending <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) descending <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req   <= req_type;
      value <= item_value;
    end
  end

  // result of the chain walk
  assign found   = chain[MAX_DISTINCT].seen_match;
  assign cur_cnt = chain[MAX_DISTINCT].cnt;
  assign full    = (total >= CW'(MAX_TOTAL)) || (!found && (used == UW'(MAX_DISTINCT)));

  always_comb begin
    ctrl            = '0;
    ctrl.cmp        = (state == S_CMP);
    ctrl.descending = descending;
    ctrl.value      = value;
    status_c        = ST_OK_SEL(found);
    occ_c           = cur_cnt;
    case (req)
      smt_pkg::REQ_ADD: begin
        if (full) begin
          status_c = smt_pkg::ST_FULL;
        end else if (found) begin
          status_c = smt_pkg::ST_OK;
          ctrl.inc = do_upd;
          occ_c    = cur_cnt + 1'b1;
        end else begin
          status_c = smt_pkg::ST_OK;
          ctrl.ins = do_upd;
          occ_c    = CW'(1);
        end
      end
      smt_pkg::REQ_REMOVE: begin
        if (found) begin
          occ_c = cur_cnt - 1'b1;
          if (cur_cnt == CW'(1)) ctrl.del = do_upd;
          else ctrl.dec = do_upd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      total <= '0;
    end else if (do_upd) begin
      if (ctrl.ins) used <= used + 1'b1;
      else if (ctrl.del) used <= used - 1'b1;
      if (ctrl.ins || ctrl.inc) total <= total + 1'b1;
      else if (ctrl.del || ctrl.dec) total <= total - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_upd) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_upd) begin
      status      <= status_c;
      occurrences <= occ_c;
      if (ctrl.ins || ctrl.inc) total_items <= total + 1'b1;
      else if (ctrl.del || ctrl.dec) total_items <= total - 1'b1;
      else total_items <= total;
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    logic [VW-1:0] lv;
    logic [CW-1:0] lc;
    logic          lvl;
    logic [VW-1:0] rv;
    logic [CW-1:0] rc;
    logic          rvl;

    if (i == 0) begin : g_first
      assign lv  = '0;
      assign lc  = '0;
      assign lvl = 1'b0;
    end else begin : g_mid_l
      assign lv  = cell_val[i-1];
      assign lc  = cell_cnt[i-1];
      assign lvl = cell_vld[i-1];
    end

    if (i == MAX_DISTINCT - 1) begin : g_last
      assign rv  = '0;
      assign rc  = '0;
      assign rvl = 1'b0;
    end else begin : g_mid_r
      assign rv  = cell_val[i+1];
      assign rc  = cell_cnt[i+1];
      assign rvl = cell_vld[i+1];
    end

    smt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_val   (lv),
      .left_cnt   (lc),
      .left_vld   (lvl),
      .right_val  (rv),
      .right_cnt  (rc),
      .right_vld  (rvl),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .val        (cell_val[i]),
      .cnt        (cell_cnt[i]),
      .vld        (cell_vld[i]),
      .match_flag (cell_match[i])
    );
  end

  // valid entries (packed at the low end) match the fill count in number, at most MAX_DISTINCT
  a_used_matches_cells: assert property (@(posedge clk) disable iff (rst)
    ($countones(cell_vld) == 32'(used)) && (used <= UW'(MAX_DISTINCT)))
    else $error("fill count out of step with cell valid flags");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $onehot0(cell_match))
    else $error("more than one cell holds the request value");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(MAX_TOTAL))
    else $error("item total above its limit");

  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    (do_upd && (status_c == smt_pkg::ST_FULL)) |=> ($stable(total) && $stable(used)))
    else $error("refused add changed the table");

  a_upd_follows_cmp: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |=> (state == S_UPD))
    else $error("compare cycle not followed by update");

endmodule

FILE: design/smt_cell.sv
// one entry of the sorted multiset table: value, count and valid flag
// depends on smt_pkg for ctrl_t, chain_t and field widths
module smt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  smt_pkg::ctrl_t            ctrl,
  input  logic [smt_pkg::VAL_W-1:0] left_val,
  input  logic [smt_pkg::CNT_W-1:0] left_cnt,
  input  logic                      left_vld,
  input  logic [smt_pkg::VAL_W-1:0] right_val,
  input  logic [smt_pkg::CNT_W-1:0] right_cnt,
  input  logic                      right_vld,
  input  smt_pkg::chain_t           chain_in,
  output smt_pkg::chain_t           chain_out,
  output logic [smt_pkg::VAL_W-1:0] val,
  output logic [smt_pkg::CNT_W-1:0] cnt,
  output logic                      vld,
  output logic                      match_flag
);

  logic match_q;
  logic before_q;
  logic match_c;
  logic before_c;

  always_comb begin
    match_c = vld && (val == ctrl.value);
    if (!vld) begin
      // empty cells sit after every value, so an insert lands on the first one
      before_c = 1'b1;
    end else if (ctrl.descending) begin
      before_c = $signed(ctrl.value) > $signed(val);
    end else begin
      before_c = $signed(ctrl.value) < $signed(val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q  <= 1'b0;
      before_q <= 1'b0;
    end else if (ctrl.cmp) begin
      match_q  <= match_c;
      before_q <= before_c;
    end
  end

  assign chain_out.seen_match  = chain_in.seen_match | match_q;
  assign chain_out.seen_before = chain_in.seen_before | before_q;
  assign chain_out.cnt         = match_q ? cnt : chain_in.cnt;
  assign match_flag            = match_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.del && chain_out.seen_match) begin
      vld <= right_vld;
    end else if (ctrl.ins && chain_in.seen_before) begin
      vld <= left_vld;
    end else if (ctrl.ins && before_q) begin
      vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.inc && match_q) begin
      cnt <= cnt + 1'b1;
    end else if (ctrl.dec && match_q) begin
      cnt <= cnt - 1'b1;
    end else if (ctrl.del && chain_out.seen_match) begin
      val <= right_val;
      cnt <= right_cnt;
    end else if (ctrl.ins && chain_in.seen_before) begin
      val <= left_val;
      cnt <= left_cnt;
    end else if (ctrl.ins && before_q) begin
      val <= ctrl.value;
      cnt <= smt_pkg::CNT_W'(1);
    end
  end

endmodule

FILE: tb/tb.sv
// self-checking testbench for sorted_multiset_table: directed and random request
// streams, a request-level model of the bag, and random stalls on both channels
// depends on smt_pkg and sorted_multiset_table
`timescale 1ns / 100ps

module tb;

  localparam int MAX_DISTINCT = smt_pkg::DEF_MAX_DISTINCT;
  localparam int MAX_TOTAL    = smt_pkg::DEF_MAX_TOTAL;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int POOL_N       = 20;
  localparam int HOLD_CYCLES  = 64;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [1:0]                status;
    logic [smt_pkg::CNT_W-1:0] occ;
    logic [smt_pkg::CNT_W-1:0] total;
  } resp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type = smt_pkg::REQ_LOOKUP;
  logic signed [31:0] item_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [15:0]       occurrences;
  logic [15:0]       total_items;

  // bag model state
  logic [smt_pkg::VAL_W-1:0] held_vals [MAX_DISTINCT];
  logic [smt_pkg::CNT_W-1:0] held_cnts [MAX_DISTINCT];
  int unsigned       held_used = 0;
  int unsigned       bag_total = 0;
  bit                order_desc = 1'b0;

  resp_t             pending_resp [$];
  int                errors = 0;
  bit                sender_gaps = 1'b1;
  bit                receiver_gaps = 1'b1;
  logic              hold_pending = 1'b0;
  int                quiet_cycles = 0;
  logic [smt_pkg::VAL_W-1:0] pool [POOL_N];

  sorted_multiset_table #(
    .MAX_DISTINCT(MAX_DISTINCT),
    .MAX_TOTAL   (MAX_TOTAL)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .occurrences(occurrences),
    .total_items(total_items)
  );

  always #1 clk = ~clk;

  function automatic bit ranks_before(logic [smt_pkg::VAL_W-1:0] a,
                                      logic [smt_pkg::VAL_W-1:0] b);
    if (order_desc) return $signed(a) > $signed(b);
    return $signed(a) < $signed(b);
  endfunction

  // applies one request to the bag model and returns the response it must produce
  function automatic resp_t apply_request(logic [1:0] req, logic [smt_pkg::VAL_W-1:0] v);
    resp_t r;
    int unsigned pos;
    int unsigned at;
    int unsigned i;
    bit hit;
    pos = held_used;
    for (i = 0; i < held_used; i++) begin
      if (held_vals[i] == v) begin
        pos = i;
        break;
      end
    end
    hit = pos < held_used;
    r.status = smt_pkg::ST_OK;
    r.occ = hit ? held_cnts[pos] : '0;
    case (req)
      smt_pkg::REQ_ADD: begin
        if (bag_total >= MAX_TOTAL || (!hit && held_used >= MAX_DISTINCT)) begin
          r.status = smt_pkg::ST_FULL;
        end else if (hit) begin
          held_cnts[pos] = held_cnts[pos] + 1'b1;
          bag_total++;
          r.occ = held_cnts[pos];
        end else begin
          at = held_used;
          for (i = 0; i < held_used; i++) begin
            if (ranks_before(v, held_vals[i])) begin
              at = i;
              break;
            end
          end
          for (i = held_used; i > at; i--) begin
            held_vals[i] = held_vals[i-1];
            held_cnts[i] = held_cnts[i-1];
          end
          held_vals[at] = v;
          held_cnts[at] = smt_pkg::CNT_W'(1);
          held_used++;
          bag_total++;
          r.occ = smt_pkg::CNT_W'(1);
        end
      end
      smt_pkg::REQ_REMOVE: begin
        if (!hit) begin
          r.status = smt_pkg::ST_NOTFOUND;
        end else begin
          held_cnts[pos] = held_cnts[pos] - 1'b1;
          bag_total--;
          r.occ = held_cnts[pos];
          if (held_cnts[pos] == 0) begin
            for (i = pos; i + 1 < held_used; i++) begin
              held_vals[i] = held_vals[i+1];
              held_cnts[i] = held_cnts[i+1];
            end
            held_used--;
          end
        end
      end
      default: begin
        // lookup and the unused code only read
        if (!hit) r.status = smt_pkg::ST_NOTFOUND;
      end
    endcase
    r.total = bag_total[smt_pkg::CNT_W-1:0];
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_req(logic [1:0] req, logic [smt_pkg::VAL_W-1:0] v);
    if (sender_gaps && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    item_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_resp.push_back(apply_request(req, v));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_order(bit desc);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we    <= 1'b0;
    order_desc = desc;
  endtask

  // removes every held occurrence, entry at the head of the sort order first
  task automatic drain_bag();
    logic [smt_pkg::VAL_W-1:0] v;
    int unsigned c;
    while (held_used != 0) begin
      v = held_vals[0];
      c = held_cnts[0];
      repeat (c) send_req(smt_pkg::REQ_REMOVE, v);
    end
  endtask

  task automatic test_basic_ops();
    set_order(1'b0);
    send_req(smt_pkg::REQ_LOOKUP, 32'd0);
    send_req(smt_pkg::REQ_REMOVE, 32'd5);
    send_req(smt_pkg::REQ_ADD, 32'h8000_0000);
    send_req(smt_pkg::REQ_ADD, 32'h7fff_ffff);
    send_req(smt_pkg::REQ_ADD, 32'd0);
    send_req(smt_pkg::REQ_ADD, 32'd0);
    send_req(smt_pkg::REQ_ADD, 32'hffff_ffff);
    send_req(smt_pkg::REQ_LOOKUP, 32'hffff_ffff);
    send_req(REQ_SPARE, 32'd0);
    send_req(REQ_SPARE, 32'd9);
    send_req(smt_pkg::REQ_REMOVE, 32'd0);
    send_req(smt_pkg::REQ_REMOVE, 32'd0);
    send_req(smt_pkg::REQ_LOOKUP, 32'd0);
    send_req(smt_pkg::REQ_REMOVE, 32'h8000_0000);
    send_req(smt_pkg::REQ_REMOVE, 32'h7fff_ffff);
    send_req(smt_pkg::REQ_REMOVE, 32'hffff_ffff);
    // emptied bag must take new values again
    send_req(smt_pkg::REQ_ADD, 32'd7);
    send_req(smt_pkg::REQ_LOOKUP, 32'd7);
    send_req(smt_pkg::REQ_REMOVE, 32'd7);
    wait_idle();
  endtask

  task automatic test_table_full();
    int i;
    set_order(1'b1);
    for (i = 0; i < MAX_DISTINCT; i++) send_req(smt_pkg::REQ_ADD, 32'(i * 37 - 300));
    send_req(smt_pkg::REQ_ADD, 32'h1234_5678);
    send_req(smt_pkg::REQ_ADD, 32'(-300));
    send_req(smt_pkg::REQ_LOOKUP, 32'h1234_5678);
    drain_bag();
    wait_idle();
  endtask

  task automatic test_backpressure();
    int i;
    sender_gaps = 1'b0;
    hold_pending <= 1'b1;
    for (i = 0; i < 14; i++) begin
      send_req(i % 3 == 2 ? smt_pkg::REQ_REMOVE : smt_pkg::REQ_ADD, 32'(i % 4));
    end
    drain_bag();
    sender_gaps = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_bag(int n, bit desc, bit calm, bit empty_after);
    int k;
    int r;
    logic [1:0] req;
    logic [smt_pkg::VAL_W-1:0] v;
    set_order(desc);
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    for (k = 4; k < POOL_N; k++) pool[k] = $urandom;
    sender_gaps   = !calm;
    receiver_gaps = !calm;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) req = smt_pkg::REQ_ADD;
      else if (r < 78) req = smt_pkg::REQ_REMOVE;
      else if (r < 95) req = smt_pkg::REQ_LOOKUP;
      else req = REQ_SPARE;
      v = ($urandom_range(19) == 0) ? $urandom : pool[$urandom_range(POOL_N - 1)];
      send_req(req, v);
    end
    if (empty_after) drain_bag();
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    wait_idle();
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= receiver_gaps && ($urandom_range(99) < 7);
    end
  end

  // response checker
  always @(posedge clk) begin
    resp_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_resp.size() == 0) begin
        $display("%0t: unexpected transaction status %0d occurrences %0d total %0d",
                 $time, status, occurrences, total_items);
        errors++;
      end else begin
        exp_r = pending_resp.pop_front();
        if (status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
          errors++;
        end
        if (occurrences !== exp_r.occ) begin
          $display("%0t: occurrences expected %0d actual %0d", $time, exp_r.occ,
                   occurrences);
          errors++;
        end
        if (total_items !== exp_r.total) begin
          $display("%0t: total_items expected %0d actual %0d", $time, exp_r.total,
                   total_items);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_table_full();
    test_backpressure();
    test_random_bag(300, 1'b0, 1'b0, 1'b1);
    test_random_bag(300, 1'b1, 1'b0, 1'b1);
    test_random_bag(300, 1'b0, 1'b1, 1'b0);
    // order flips while values are held
    test_random_bag(300, 1'b1, 1'b0, 1'b1);
    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sorted_multiset_table.f
design/smt_pkg.sv
design/smt_cell.sv
design/sorted_multiset_table.sv
tb/tb.sv
